### rtl/core/ray_cylinder_intersect_unit_assert.svh
// Assertion macros used by the port-level checker file of the ray/cylinder block.
`ifndef RAY_CYLINDER_INTERSECT_UNIT_ASSERT_SVH
`define RAY_CYLINDER_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCI_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCI_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rci_pkg.sv
// Types, constants and helper functions of the ray/cylinder intersection block.
package rci_pkg;

  localparam int SQRT_STEPS = 64;
  localparam int DIV_STEPS  = 31;

  localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] EPS_T = 31'd65;

  localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
  localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

  typedef enum logic [1:0] {
    CFG_BOTTOM_Y       = 2'd0,
    CFG_TOP_Y          = 2'd1,
    CFG_CYL_RADIUS     = 2'd2,
    CFG_INVERSE_RADIUS = 2'd3
  } rci_cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] bottom_y;
    logic signed [31:0] top_y;
    logic [30:0]        cyl_radius;
    logic [30:0]        inverse_radius;
  } rci_cfg_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } rci_in_t;

  typedef struct packed {
    logic               hit_flag;
    logic [30:0]        hit_distance;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } rci_out_t;

  // Ray carried down the pipeline; live drops once the ray is known to miss.
  typedef struct packed {
    logic               live;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } rci_ray_t;

  typedef struct packed {
    rci_ray_t           ray;
    logic [63:0]        a;
    logic signed [64:0] hv;
  } rci_geo_t;

  typedef struct packed {
    logic        ok;
    logic [30:0] t;
  } rci_cand_t;

  function automatic logic signed [31:0] sat32(logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

### rtl/core/ray_cylinder_intersect_unit.sv
// Top level of the ray against finite y-axis cylinder intersection pipeline.
//
// Each input word is one ray (origin and direction, signed Q16.16); each ray
// gives exactly one output word: hit flag, distance, inward normal (x, z) and
// hit point, or an all-zero word on a miss. Words are accepted on a rising
// edge where valid is high and stall is low, on both channels.
// The pipeline is 109 register stages deep. A new ray is taken in every
// cycle where in_stall_o is low: throughput is one word per cycle unless the
// receiver stalls. The depth comes from the 64-stage square root of the
// discriminant and the 31-stage restoring divider that forms the distances.
// The whole pipeline advances together. When the output word is valid and the
// receiver stalls, every stage holds and in_stall_o is raised in the same
// cycle, so nothing is dropped or repeated.
// Reset clears all valid bits and loads the default cylinder: bottom -1.0,
// top +1.0, radius 1.0, reciprocal radius 1.0. Configuration registers are
// written through cfg_we_i, cfg_index_i and cfg_wdata_i, and should only be
// changed while no ray is in flight.
module ray_cylinder_intersect_unit import rci_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rci_in_t     in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rci_out_t    out_word_o
);

  rci_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bottom_y       <= -32'sd65536;
      cfg_q.top_y          <= 32'sd65536;
      cfg_q.cyl_radius     <= 31'd65536;
      cfg_q.inverse_radius <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BOTTOM_Y:       cfg_q.bottom_y       <= $signed(cfg_wdata_i);
        CFG_TOP_Y:          cfg_q.top_y          <= $signed(cfg_wdata_i);
        CFG_CYL_RADIUS:     cfg_q.cyl_radius     <= cfg_wdata_i[30:0];
        CFG_INVERSE_RADIUS: cfg_q.inverse_radius <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the finished word is held back.
  logic en;
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  logic            quad_valid, sqrt_valid, div_valid;
  rci_geo_t        quad_geo, sqrt_geo;
  logic [127:0]    quad_disc;
  logic [63:0]     sqrt_root;
  rci_ray_t        div_ray;
  rci_cand_t [1:0] div_cand;

  // Coefficients and discriminant.
  rci_quad u_quad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (quad_valid),
    .geo_o   (quad_geo),
    .disc_o  (quad_disc)
  );

  // Square root of the discriminant.
  rci_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quad_valid),
    .geo_i   (quad_geo),
    .disc_i  (quad_disc),
    .valid_o (sqrt_valid),
    .geo_o   (sqrt_geo),
    .root_o  (sqrt_root)
  );

  // Both candidate distances, saturated and checked against the epsilon.
  rci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .geo_i   (sqrt_geo),
    .root_i  (sqrt_root),
    .valid_o (div_valid),
    .ray_o   (div_ray),
    .cand_o  (div_cand)
  );

  // Height test, choice of root, point and normal.
  rci_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (div_valid),
    .ray_i   (div_ray),
    .cand_i  (div_cand),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

endmodule

### rtl/core/rci_quad.sv
// Front stages: wall quadratic coefficients and discriminant, five registers deep.
module rci_quad import rci_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  rci_cfg_t     cfg_i,
  input  logic         valid_i,
  input  rci_in_t      word_i,
  output logic         valid_o,
  output rci_geo_t     geo_o,
  output logic [127:0] disc_o
);

  // Stage 1: all 32x32 products.
  logic               v1_q;
  rci_ray_t           ray1_q;
  logic signed [63:0] dxdx_q, dzdz_q, oxdx_q, ozdz_q, oxox_q, ozoz_q;
  logic [61:0]        r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray1_q.live <= 1'b1;
      ray1_q.ox   <= word_i.origin_x;
      ray1_q.oy   <= word_i.origin_y;
      ray1_q.oz   <= word_i.origin_z;
      ray1_q.dx   <= word_i.dir_x;
      ray1_q.dy   <= word_i.dir_y;
      ray1_q.dz   <= word_i.dir_z;
      dxdx_q      <= word_i.dir_x * word_i.dir_x;
      dzdz_q      <= word_i.dir_z * word_i.dir_z;
      oxdx_q      <= word_i.origin_x * word_i.dir_x;
      ozdz_q      <= word_i.origin_z * word_i.dir_z;
      oxox_q      <= word_i.origin_x * word_i.origin_x;
      ozoz_q      <= word_i.origin_z * word_i.origin_z;
      r2_q        <= cfg_i.cyl_radius * cfg_i.cyl_radius;
    end
  end

  // Stage 2: a, h, c and their magnitudes.
  logic               v2_q;
  rci_geo_t           geo2_q, geo2_d;
  logic [63:0]        hm2_q, hm2_d, cm2_q, cm2_d;
  logic               cneg2_q, cneg2_d;
  logic [63:0]        sq_d;
  logic signed [64:0] hvn_d, cv_d, cvn_d;

  always_comb begin
    geo2_d.a  = $unsigned(dxdx_q) + $unsigned(dzdz_q);
    geo2_d.hv = {oxdx_q[63], oxdx_q} + {ozdz_q[63], ozdz_q};
    geo2_d.ray      = ray1_q;
    geo2_d.ray.live = ray1_q.live & (geo2_d.a != 64'd0);
    hvn_d  = 65'sd0 - geo2_d.hv;
    hm2_d  = geo2_d.hv[64] ? hvn_d[63:0] : geo2_d.hv[63:0];
    sq_d   = $unsigned(oxox_q) + $unsigned(ozoz_q);
    cv_d   = $signed({1'b0, sq_d}) - $signed({3'b000, r2_q});
    cvn_d  = 65'sd0 - cv_d;
    cneg2_d = cv_d[64];
    cm2_d  = cneg2_d ? cvn_d[63:0] : cv_d[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo2_q  <= geo2_d;
      hm2_q   <= hm2_d;
      cm2_q   <= cm2_d;
      cneg2_q <= cneg2_d;
    end
  end

  // Stage 3: 32-bit partial products of h*h and a*|c|.
  logic        v3_q, cneg3_q;
  rci_geo_t    geo3_q;
  logic [63:0] hh00_q, hh01_q, hh11_q, ac00_q, ac01_q, ac10_q, ac11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo3_q  <= geo2_q;
      cneg3_q <= cneg2_q;
      hh00_q  <= hm2_q[31:0] * hm2_q[31:0];
      hh01_q  <= hm2_q[31:0] * hm2_q[63:32];
      hh11_q  <= hm2_q[63:32] * hm2_q[63:32];
      ac00_q  <= geo2_q.a[31:0] * cm2_q[31:0];
      ac01_q  <= geo2_q.a[31:0] * cm2_q[63:32];
      ac10_q  <= geo2_q.a[63:32] * cm2_q[31:0];
      ac11_q  <= geo2_q.a[63:32] * cm2_q[63:32];
    end
  end

  // Stage 4: assemble the two 128-bit products.
  logic         v4_q, cneg4_q;
  rci_geo_t     geo4_q;
  logic [127:0] hh4_q, ac4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo4_q  <= geo3_q;
      cneg4_q <= cneg3_q;
      hh4_q   <= {64'd0, hh00_q} + ({64'd0, hh01_q} << 33) + {hh11_q, 64'd0};
      ac4_q   <= {64'd0, ac00_q} + ({64'd0, ac01_q} << 32) + ({64'd0, ac10_q} << 32)
               + {ac11_q, 64'd0};
    end
  end

  // Stage 5: discriminant h^2 - a*c; a negative one is a miss.
  logic         v5_q;
  rci_geo_t     geo5_q, geo5_d;
  logic [127:0] disc5_q, disc5_d;

  always_comb begin
    geo5_d = geo4_q;
    if (cneg4_q) begin
      disc5_d = hh4_q + ac4_q;
    end else begin
      disc5_d = hh4_q - ac4_q;
      if (hh4_q < ac4_q) begin
        geo5_d.ray.live = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo5_q  <= geo5_d;
      disc5_q <= disc5_d;
    end
  end

  assign valid_o = v5_q;
  assign geo_o   = geo5_q;
  assign disc_o  = disc5_q;

endmodule

### rtl/core/rci_isqrt.sv
// Floor square root of the 128-bit discriminant, one result bit per stage.
module rci_isqrt import rci_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  rci_geo_t     geo_i,
  input  logic [127:0] disc_i,
  output logic         valid_o,
  output rci_geo_t     geo_o,
  output logic [63:0]  root_o
);

  logic         v_q   [SQRT_STEPS];
  rci_geo_t     geo_q [SQRT_STEPS];
  logic [127:0] rem_q [SQRT_STEPS];
  logic [127:0] res_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [127:0] Bit4 = 128'd1 << (2 * (SQRT_STEPS - 1 - k));

    logic         v_in;
    rci_geo_t     geo_in;
    logic [127:0] rem_in, res_in, trial;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign geo_in = geo_i;
      assign rem_in = disc_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign geo_in = geo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + Bit4;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        geo_q[k] <= geo_in;
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + Bit4;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign geo_o   = geo_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][63:0];

endmodule

### rtl/core/rci_div.sv
// Both root distances t = num * 2^16 / a, restoring division one quotient bit per stage.
module rci_div import rci_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rci_geo_t        geo_i,
  input  logic [63:0]     root_i,
  output logic            valid_o,
  output rci_ray_t        ray_o,
  output rci_cand_t [1:0] cand_o
);

  // Stage A: numerators -h - e (near root) and -h + e (far root).
  logic             va_q;
  rci_ray_t         raya_q;
  logic [63:0]      aa_q;
  logic [1:0][65:0] numa_q;
  logic signed [65:0] nh_d;

  assign nh_d = 66'sd0 - 66'(geo_i.hv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raya_q    <= geo_i.ray;
      aa_q      <= geo_i.a;
      numa_q[0] <= nh_d - $signed({2'b00, root_i});
      numa_q[1] <= nh_d + $signed({2'b00, root_i});
    end
  end

  // Stage B: sign check, shift by 16 and the saturation compare.
  logic             vb_q;
  rci_ray_t         rayb_q;
  logic [63:0]      ab_q;
  logic [1:0][80:0] remb_q, remb_d;
  logic [1:0]       satb_q, satb_d, okb_q, okb_d;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      remb_d[r] = {numa_q[r][64:0], 16'd0};
      satb_d[r] = {14'd0, remb_d[r]} >= {aa_q, 31'd0};
      okb_d[r]  = raya_q.live & ~numa_q[r][65] & (numa_q[r] != 66'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rayb_q <= raya_q;
      ab_q   <= aa_q;
      remb_q <= remb_d;
      satb_q <= satb_d;
      okb_q  <= okb_d;
    end
  end

  // Division steps, most significant quotient bit first.
  logic             v_q   [DIV_STEPS];
  rci_ray_t         ray_q [DIV_STEPS];
  logic [63:0]      a_q   [DIV_STEPS];
  logic [1:0][80:0] rem_q [DIV_STEPS];
  logic [1:0][30:0] quo_q [DIV_STEPS];
  logic [1:0]       sat_q [DIV_STEPS];
  logic [1:0]       ok_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int Shift = DIV_STEPS - 1 - k;

    logic             v_in;
    rci_ray_t         ray_in;
    logic [63:0]      a_in;
    logic [1:0][80:0] rem_in, rem_d;
    logic [1:0][30:0] quo_in, quo_d;
    logic [1:0]       sat_in, ok_in;
    logic [94:0]      dsub;

    if (k == 0) begin : g_first
      assign v_in   = vb_q;
      assign ray_in = rayb_q;
      assign a_in   = ab_q;
      assign rem_in = remb_q;
      assign quo_in = '0;
      assign sat_in = satb_q;
      assign ok_in  = okb_q;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign ray_in = ray_q[k-1];
      assign a_in   = a_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sat_in = sat_q[k-1];
      assign ok_in  = ok_q[k-1];
    end

    assign dsub = {31'd0, a_in} << Shift;

    always_comb begin
      for (int r = 0; r < 2; r++) begin
        if ({14'd0, rem_in[r]} >= dsub) begin
          rem_d[r] = rem_in[r] - dsub[80:0];
          quo_d[r] = {quo_in[r][29:0], 1'b1};
        end else begin
          rem_d[r] = rem_in[r];
          quo_d[r] = {quo_in[r][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ray_q[k] <= ray_in;
        a_q[k]   <= a_in;
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        sat_q[k] <= sat_in;
        ok_q[k]  <= ok_in;
      end
    end
  end

  // Stage C: saturate and apply the epsilon test.
  logic            vc_q;
  rci_ray_t        rayc_q;
  rci_cand_t [1:0] candc_q, candc_d;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      candc_d[r].t  = sat_q[DIV_STEPS-1][r] ? T_MAX : quo_q[DIV_STEPS-1][r];
      candc_d[r].ok = ok_q[DIV_STEPS-1][r] & (candc_d[r].t > EPS_T);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= v_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rayc_q  <= ray_q[DIV_STEPS-1];
      candc_q <= candc_d;
    end
  end

  assign valid_o = vc_q;
  assign ray_o   = rayc_q;
  assign cand_o  = candc_q;

endmodule

### rtl/core/rci_back.sv
// Back stages: height test, root choice, hit point, normal and the output register.
module rci_back import rci_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rci_cfg_t        cfg_i,
  input  logic            valid_i,
  input  rci_ray_t        ray_i,
  input  rci_cand_t [1:0] cand_i,
  output logic            valid_o,
  output rci_out_t        word_o
);

  // B1: height products t*dy for both roots.
  logic               v1_q;
  rci_ray_t           ray1_q;
  rci_cand_t [1:0]    cand1_q;
  logic signed [63:0] yp1_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray1_q   <= ray_i;
      cand1_q  <= cand_i;
      yp1_q[0] <= $signed({1'b0, cand_i[0].t}) * ray_i.dy;
      yp1_q[1] <= $signed({1'b0, cand_i[1].t}) * ray_i.dy;
    end
  end

  // B2: strict height test; the near root wins when both count.
  logic               v2_q, hit2_q, hit2_d;
  rci_ray_t           ray2_q;
  logic [30:0]        t2_q, t2_d;
  logic signed [63:0] ysh_d [2];
  logic signed [48:0] yh_d  [2];
  logic [1:0]         in_d;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      ysh_d[r] = yp1_q[r] >>> 16;
      yh_d[r]  = 49'(ray1_q.oy) + $signed(ysh_d[r][48:0]);
      in_d[r]  = cand1_q[r].ok & ray1_q.live & (yh_d[r] > 49'(cfg_i.bottom_y))
               & (yh_d[r] < 49'(cfg_i.top_y));
    end
    hit2_d = in_d[0] | in_d[1];
    t2_d   = in_d[0] ? cand1_q[0].t : cand1_q[1].t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray2_q <= ray1_q;
      hit2_q <= hit2_d;
      t2_q   <= t2_d;
    end
  end

  // B3: t*d for the hit point.
  logic               v3_q, hit3_q;
  rci_ray_t           ray3_q;
  logic [30:0]        t3_q;
  logic signed [63:0] mx3_q, my3_q, mz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray3_q <= ray2_q;
      hit3_q <= hit2_q;
      t3_q   <= t2_q;
      mx3_q  <= $signed({1'b0, t2_q}) * ray2_q.dx;
      my3_q  <= $signed({1'b0, t2_q}) * ray2_q.dy;
      mz3_q  <= $signed({1'b0, t2_q}) * ray2_q.dz;
    end
  end

  // B4: point = origin + floor(t*d / 2^16), saturated.
  logic               v4_q, hit4_q;
  logic [30:0]        t4_q;
  logic signed [31:0] px4_q, py4_q, pz4_q;
  logic signed [63:0] sx_d, sy_d, sz_d;

  assign sx_d = mx3_q >>> 16;
  assign sy_d = my3_q >>> 16;
  assign sz_d = mz3_q >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit4_q <= hit3_q;
      t4_q   <= t3_q;
      px4_q  <= sat32(49'(ray3_q.ox) + $signed(sx_d[48:0]));
      py4_q  <= sat32(49'(ray3_q.oy) + $signed(sy_d[48:0]));
      pz4_q  <= sat32(49'(ray3_q.oz) + $signed(sz_d[48:0]));
    end
  end

  // B5: point times the reciprocal radius.
  logic               v5_q, hit5_q;
  logic [30:0]        t5_q;
  logic signed [31:0] px5_q, py5_q, pz5_q;
  logic signed [63:0] nxp5_q, nzp5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit5_q <= hit4_q;
      t5_q   <= t4_q;
      px5_q  <= px4_q;
      py5_q  <= py4_q;
      pz5_q  <= pz4_q;
      nxp5_q <= px4_q * $signed({1'b0, cfg_i.inverse_radius});
      nzp5_q <= pz4_q * $signed({1'b0, cfg_i.inverse_radius});
    end
  end

  // B6: negated, saturated normal; a miss clears every field.
  logic               v6_q;
  rci_out_t           out6_q, out6_d;
  logic signed [63:0] nxs_d, nzs_d;
  logic signed [48:0] nxn_d, nzn_d;

  always_comb begin
    nxs_d = nxp5_q >>> 16;
    nzs_d = nzp5_q >>> 16;
    nxn_d = 49'sd0 - $signed(nxs_d[48:0]);
    nzn_d = 49'sd0 - $signed(nzs_d[48:0]);
    out6_d = '0;
    if (hit5_q) begin
      out6_d.hit_flag     = 1'b1;
      out6_d.hit_distance = t5_q;
      out6_d.normal_x     = sat32(nxn_d);
      out6_d.normal_z     = sat32(nzn_d);
      out6_d.point_x      = px5_q;
      out6_d.point_y      = py5_q;
      out6_d.point_z      = pz5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en_i) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out6_q <= out6_d;
    end
  end

  assign valid_o = v6_q;
  assign word_o  = out6_q;

endmodule

### rtl/core/rci_checker.sv
// Port-level checks of the ray/cylinder intersection unit and their binding.
`include "ray_cylinder_intersect_unit_assert.svh"

module rci_checker import rci_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rci_out_t out_word_o
);

  `RCI_ASSERT_IMP(a_miss_clear, clk_i, rst_ni, out_valid_o && !out_word_o.hit_flag, out_word_o.hit_distance == '0 && out_word_o.normal_x == '0 && out_word_o.normal_z == '0 && out_word_o.point_x == '0 && out_word_o.point_y == '0 && out_word_o.point_z == '0, "miss word carries nonzero fields")
  `RCI_ASSERT_IMP(a_hit_eps, clk_i, rst_ni, out_valid_o && out_word_o.hit_flag, out_word_o.hit_distance > 31'd65, "hit distance not above epsilon")
  `RCI_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held output word")
  `RCI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")

endmodule

bind ray_cylinder_intersect_unit rci_checker u_rci_checker (.*);

### bench/ray_cylinder_intersect_unit_checker.sv
// Checker for the ray/cylinder block: predicts each output word and compares.
`timescale 1ns / 100ps
module ray_cylinder_intersect_unit_checker import rci_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  rci_in_t     in_word_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  rci_out_t    out_word_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          hit_count_o
);

  rci_cfg_t cyl;
  rci_out_t hit_queue[$];

  function automatic logic signed [63:0] floor_q16(logic signed [127:0] v);
    return 64'(v >>> 16);
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Distance for one root numerator, or -1 when this root does not count.
  function automatic logic signed [63:0] root_dist(logic signed [129:0] num,
      logic [63:0] a, logic signed [63:0] oy, logic signed [63:0] dy);
    logic [145:0] q;
    logic signed [63:0] t, yh;
    if (num <= 0) return -1;
    q = ({16'd0, num} << 16) / a;
    t = (q > 146'h7FFFFFFF) ? 64'sh7FFFFFFF : 64'(q);
    if (t <= 65) return -1;
    yh = oy + floor_q16(128'(t) * 128'(dy));
    if (!(yh > 64'(cyl.bottom_y) && yh < 64'(cyl.top_y))) return -1;
    return t;
  endfunction

  function automatic rci_out_t trace_cylinder(rci_in_t r);
    rci_out_t res;
    logic signed [63:0] ox, oy, oz, dx, dy, dz, t, px, py, pz, ir;
    logic [63:0] a;
    logic signed [129:0] h, c, disc, e, lo;
    res = '0;
    ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
    dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
    a = 64'(dx * dx) + 64'(dz * dz);
    if (a == 0) return res;
    h = 130'(ox * dx) + 130'(oz * dz);
    // The sum of squares can reach 2^63, so it is kept unsigned.
    c = 130'($unsigned(64'(ox * ox)) + $unsigned(64'(oz * oz)))
        - 130'(64'(cyl.cyl_radius) * 64'(cyl.cyl_radius));
    disc = h * h - $signed({66'd0, a}) * c;
    if (disc < 0) return res;
    // Floor square root, bit by bit from the top.
    e = 0;
    for (int b = 63; b >= 0; b--) begin
      lo = e | (130'sd1 << b);
      if (lo * lo <= disc) e = lo;
    end
    t = root_dist(-h - e, a, oy, dy);
    if (t < 0) t = root_dist(-h + e, a, oy, dy);
    if (t < 0) return res;
    ir = 64'(cyl.inverse_radius);
    px = clamp32(ox + floor_q16(128'(t) * 128'(dx)));
    py = clamp32(oy + floor_q16(128'(t) * 128'(dy)));
    pz = clamp32(oz + floor_q16(128'(t) * 128'(dz)));
    res.hit_flag = 1'b1;
    res.hit_distance = t[30:0];
    res.normal_x = 32'(clamp32(-floor_q16(128'(px) * 128'(ir))));
    res.normal_z = 32'(clamp32(-floor_q16(128'(pz) * 128'(ir))));
    res.point_x = 32'(px);
    res.point_y = 32'(py);
    res.point_z = 32'(pz);
    return res;
  endfunction

  assign pending_o = hit_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rci_out_t want;
    if (!rst_ni) begin
      cyl <= '{bottom_y: -32'sd65536, top_y: 32'sd65536,
               cyl_radius: 31'd65536, inverse_radius: 31'd65536};
      fail_count_o <= 0;
      hit_count_o <= 0;
      hit_queue.delete();
    end else begin
      if (cfg_we_i) begin
        case (rci_cfg_idx_e'(cfg_index_i))
          CFG_BOTTOM_Y:       cyl.bottom_y <= cfg_wdata_i;
          CFG_TOP_Y:          cyl.top_y <= cfg_wdata_i;
          CFG_CYL_RADIUS:     cyl.cyl_radius <= cfg_wdata_i[30:0];
          CFG_INVERSE_RADIUS: cyl.inverse_radius <= cfg_wdata_i[30:0];
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, out_word_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = hit_queue.pop_front();
          if (want !== out_word_o) begin
            $display("%0t: mismatch, expected %h, got %h", $time, want, out_word_o);
            fail_count_o <= fail_count_o + 1;
          end
          if (want.hit_flag) hit_count_o <= hit_count_o + 1;
        end
      end
      if (in_valid_i && !in_stall_o) hit_queue.push_back(trace_cylinder(in_word_i));
    end
  end

endmodule

### bench/ray_cylinder_intersect_unit_tb.sv
// Stimulus and verdict for the ray/cylinder intersection block.
`timescale 1ns / 100ps
module ray_cylinder_intersect_unit_tb;
  import rci_pkg::*;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rci_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rci_out_t out_word_o;
  int fail_count, pending, hit_count, cycle_count = 0, ray_count = 0;
  logic stall_busy = 1'b0;

  always #5 clk_i = ~clk_i;

  ray_cylinder_intersect_unit DUT (.*);

  ray_cylinder_intersect_unit_checker checker_i (
    .*, .fail_count_o(fail_count), .pending_o(pending), .hit_count_o(hit_count));

  // Gap lengths: mostly zero or short, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls at random, with calm stretches where it never stalls.
  // Stall is already low whenever a new stretch starts.
  always @(posedge clk_i) begin
    int n;
    if (!stall_busy) begin
      stall_busy <= 1'b1;
      fork begin
        n = ($urandom_range(3) == 0) ? $urandom_range(20, 80) : 0;
        repeat (n) @(posedge clk_i);
        n = gap_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        @(posedge clk_i);
        stall_busy <= 1'b0;
      end join_none
    end
  end

  // The timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("ray_cylinder_intersect_unit verification failed");
      $finish;
    end
  end

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_reg(rci_cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_cylinder(logic [31:0] bot, logic [31:0] top, logic [31:0] rad,
                              logic [31:0] irad);
    write_reg(CFG_BOTTOM_Y, bot);
    write_reg(CFG_TOP_Y, top);
    write_reg(CFG_CYL_RADIUS, rad);
    write_reg(CFG_INVERSE_RADIUS, irad);
    cfg_we_i <= 1'b0;
  endtask

  // Presents one ray word, holding it until accepted, then a random gap.
  task automatic send_ray(rci_in_t w);
    int g;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    ray_count++;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Waits until all words are back, plus the pipeline depth for safety.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Scale a value to a small Q16.16 span around zero.
  function automatic logic [31:0] near(int span_q16);
    return 32'($urandom_range(0, 2 * span_q16) - span_q16);
  endfunction

  // A ray near the wall: origin within four radii in x and z, inward half the time.
  function automatic rci_in_t aimed_ray(int rad);
    rci_in_t w;
    w.origin_x = near(4 * rad);
    w.origin_y = near(3 << 16);
    w.origin_z = near(4 * rad);
    w.dir_x = near(1 << 16);
    w.dir_y = near(1 << 15);
    w.dir_z = near(1 << 16);
    if ($urandom_range(1)) begin
      w.dir_x = -w.origin_x >>> $urandom_range(1, 3);
      w.dir_z = -w.origin_z >>> $urandom_range(1, 3);
    end
    return w;
  endfunction

  function automatic rci_in_t noise_ray();
    rci_in_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return w;
  endfunction

  initial begin
    rci_in_t w;
    int rad;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays on the reset cylinder: straight hits, from inside, tangent,
    // parallel to the axis, a miss, extreme fields and a very far hit.
    send_ray('{32'sh0002_0000, 0, 0, -32'sh0001_0000, 0, 0});
    send_ray('{0, 0, 0, 32'sh0001_0000, 32'sh0000_4000, 0});
    send_ray('{32'sh0002_0000, 0, 32'sh0001_0000, -32'sh0001_0000, 0, 0});
    send_ray('{0, 0, 0, 0, 32'sh0001_0000, 0});
    send_ray('{32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0});
    send_ray('{32'sh0002_0000, 32'sh0003_0000, 0, -32'sh0001_0000, 0, 0});
    send_ray('{0, 0, 0, 0, 0, 32'sh0000_0001});
    send_ray('{0, 0, 0, 32'sh0000_0001, 0, 0});
    send_ray('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    send_ray('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    send_ray('{32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0});
    send_ray('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    // The sender waits here until every word is back.
    drain();

    // Crossed bounds give only misses; then extreme register values.
    set_cylinder(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_ray('{32'sh0002_0000, 0, 0, -32'sh0001_0000, 0, 0});
    send_ray('{0, 0, 0, 32'sh0001_0000, 0, 0});
    drain();
    set_cylinder(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray('{0, 32'sh1234_0000, 0, 32'sh0000_0100, 32'sh7FFF_FFFF, 0});
    send_ray('{0, 0, 0, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001});
    send_ray(noise_ray());
    drain();
    set_cylinder(0, 0, 0, 0);
    send_ray('{0, 0, 0, 32'sh0001_0000, 0, 0});
    drain();

    // Random phases over several cylinders: mostly aimed rays, some noise.
    for (int ph = 0; ph < 8; ph++) begin
      rad = (ph == 7) ? 32'sh0100_0000 : $urandom_range(1 << 12, 3 << 16);
      set_cylinder(-$urandom_range(1 << 12, 2 << 16), $urandom_range(1 << 12, 2 << 16),
                   rad, (ph % 2) ? $urandom : ((1 << 30) / (rad >>> 2)) << 2);
      for (int i = 0; i < 200; i++) begin
        w = ($urandom_range(9) < 8) ? aimed_ray(rad) : noise_ray();
        send_ray(w);
      end
      drain();
    end

    $display("Sent %0d rays over twelve cylinder settings; %0d came back as hits.",
             ray_count, hit_count);
    if (fail_count == 0) begin
      $display("ray_cylinder_intersect_unit verification clean");
    end else begin
      $display("ray_cylinder_intersect_unit verification failed");
    end
    $finish;
  end

endmodule
